[rtl/tdpq_pkg.sv]
// ----------------------------------------------------------------------------
// tdpq_pkg: shared types and constants of the task dispatch priority queue
// Item and result layouts, command codes, status codes and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpq_pkg;

  localparam int MAX_WORKERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CMDQ_DEPTH      = 2;

  localparam int TASK_W   = 16;
  localparam int PRIO_W   = 16;
  localparam int WORKER_W = 3;
  localparam int WCFG_W   = 4;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_QUEUED     = 2'd1,
    ST_FULL       = 2'd2,
    ST_IDLE       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_DONE   = 2'd1,
    CMD_STRAY  = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_FETCH = 1'b0,
    BK_EXEC  = 1'b1
  } back_state_t;

  typedef struct packed {
    logic                mode;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   priority_req;
    logic [WORKER_W-1:0] worker;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [WORKER_W-1:0] dispatch_worker;
    logic [TASK_W-1:0]   dispatch_task;
    logic                finished_valid;
    logic [TASK_W-1:0]   finished_task;
  } result_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   priority_req;
    logic [WORKER_W-1:0] worker;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/tdpq_front.sv]
// ----------------------------------------------------------------------------
// tdpq_front: command intake
// Accepts items, sorts them into submits, completions and stray completions,
// and pushes them into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpq_front #(
  parameter int MAX_WORKERS = tdpq_pkg::MAX_WORKERS_DEF
) (
  input  wire logic            start,
  input  wire tdpq_pkg::item_t item,
  input  wire logic            q_full,
  output logic                 busy,
  output logic                 push,
  output tdpq_pkg::cmd_t       cmd
);

  logic worker_ok;

  assign busy      = q_full;
  assign push      = start && !q_full;
  // A completion from a worker index beyond the pool can change nothing.
  assign worker_ok = int'(item.worker) < MAX_WORKERS;

  always_comb begin
    cmd.task_id      = item.task_id;
    cmd.priority_req = item.priority_req;
    cmd.worker       = item.worker;
    if (!item.mode) begin
      cmd.kind = tdpq_pkg::CMD_SUBMIT;
    end else if (worker_ok) begin
      cmd.kind = tdpq_pkg::CMD_DONE;
    end else begin
      cmd.kind = tdpq_pkg::CMD_STRAY;
    end
  end

endmodule

`default_nettype wire

[rtl/tdpq_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tdpq_cmd_fifo: command queue between intake and execution
// A short first-in first-out queue so that either side can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpq_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tdpq_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output tdpq_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  localparam int DEPTH = tdpq_pkg::CMDQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);

  tdpq_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [FW-1:0]  fill;

  assign empty = (fill == '0);
  assign full  = (fill == FW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/tdpq_back.sv]
// ----------------------------------------------------------------------------
// tdpq_back: command execution
// Holds the worker pool and the sorted wait queue, fetches and executes one
// command at a time and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpq_back #(
  parameter int MAX_WORKERS = tdpq_pkg::MAX_WORKERS_DEF,
  parameter int QUEUE_DEPTH = tdpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [tdpq_pkg::WCFG_W-1:0] workers_in_use,
  input  wire tdpq_pkg::cmd_t              head,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             result_valid,
  output tdpq_pkg::result_t                result
);

  localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW   = $clog2(MAX_WORKERS + 1);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LW0  = (NW > CW) ? NW : CW;
  localparam int LW   = (LW0 > tdpq_pkg::WCFG_W) ? LW0 : tdpq_pkg::WCFG_W;
  localparam int WKW  = tdpq_pkg::WORKER_W;
  localparam int TW   = tdpq_pkg::TASK_W;
  localparam int PRW  = tdpq_pkg::PRIO_W;

  tdpq_pkg::back_state_t state, state_next;
  tdpq_pkg::cmd_t        cur;
  logic [TW-1:0]         rd_task;

  logic [MAX_WORKERS-1:0] worker_busy;
  logic [TW-1:0]          worker_task [MAX_WORKERS];

  // Wait queue held in descending priority order; the head is served next.
  logic [PRW-1:0] q_prio [QUEUE_DEPTH];
  logic [TW-1:0]  q_task [QUEUE_DEPTH];
  logic [CW-1:0]  q_count;

  logic [LW-1:0]  wiu_x;
  logic [LW-1:0]  n_act;
  logic [LW-1:0]  cap;
  logic [WIDX-1:0] idle_idx;
  logic            idle_found;
  logic [WIDX-1:0] cur_idx;
  logic [QUEUE_DEPTH-1:0] ahead;

  logic            do_insert;
  logic            do_pop;
  logic            set_busy;
  logic            clr_busy;
  logic            mem_we;
  logic [WIDX-1:0] mem_addr;
  logic [TW-1:0]   mem_wdata;
  tdpq_pkg::result_t res_next;

  assign cur_idx = WIDX'(cur.worker);

  // Active worker count and queue capacity, both clamped to what exists.
  always_comb begin
    wiu_x = LW'(workers_in_use);
    if (wiu_x == '0) begin
      n_act = LW'(1);
    end else if (wiu_x > LW'(MAX_WORKERS)) begin
      n_act = LW'(MAX_WORKERS);
    end else begin
      n_act = wiu_x;
    end
    if (n_act < LW'(4)) begin
      cap = LW'(4);
    end else if (n_act > LW'(QUEUE_DEPTH)) begin
      cap = LW'(QUEUE_DEPTH);
    end else begin
      cap = n_act;
    end
  end

  // Lowest-numbered idle worker among the active ones.
  always_comb begin
    idle_idx   = '0;
    idle_found = 1'b0;
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (!worker_busy[i] && (LW'(i) < n_act)) begin
        idle_idx   = WIDX'(i);
        idle_found = 1'b1;
      end
    end
  end

  // Entries that stay ahead of a new task: valid and of at least its priority.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ahead[i] = (CW'(i) < q_count) && (q_prio[i] >= cur.priority_req);
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_insert  = 1'b0;
    do_pop     = 1'b0;
    set_busy   = 1'b0;
    clr_busy   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = cur_idx;
    mem_wdata  = q_task[0];
    res_next.status          = tdpq_pkg::ST_IDLE;
    res_next.dispatch_worker = '0;
    res_next.dispatch_task   = '0;
    res_next.finished_valid  = 1'b0;
    res_next.finished_task   = '0;
    case (state)
      tdpq_pkg::BK_FETCH: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = tdpq_pkg::BK_EXEC;
        end
      end
      tdpq_pkg::BK_EXEC: begin
        state_next = tdpq_pkg::BK_FETCH;
        case (cur.kind)
          tdpq_pkg::CMD_SUBMIT: begin
            if (idle_found) begin
              set_busy                 = 1'b1;
              mem_we                   = 1'b1;
              mem_addr                 = idle_idx;
              mem_wdata                = cur.task_id;
              res_next.status          = tdpq_pkg::ST_DISPATCHED;
              res_next.dispatch_worker = WKW'(idle_idx);
              res_next.dispatch_task   = cur.task_id;
            end else if (LW'(q_count) < cap) begin
              do_insert       = 1'b1;
              res_next.status = tdpq_pkg::ST_QUEUED;
            end else begin
              res_next.status = tdpq_pkg::ST_FULL;
            end
          end
          tdpq_pkg::CMD_DONE: begin
            if (worker_busy[cur_idx]) begin
              res_next.finished_valid = 1'b1;
              res_next.finished_task  = rd_task;
              // A worker beyond the active count retires instead of taking work.
              if ((LW'(cur.worker) < n_act) && (q_count != '0)) begin
                do_pop                   = 1'b1;
                mem_we                   = 1'b1;
                res_next.status          = tdpq_pkg::ST_DISPATCHED;
                res_next.dispatch_worker = cur.worker;
                res_next.dispatch_task   = q_task[0];
              end else begin
                clr_busy = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = tdpq_pkg::BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tdpq_pkg::BK_FETCH;
      worker_busy  <= '0;
      q_count      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == tdpq_pkg::BK_EXEC);
      if (set_busy) begin
        worker_busy[idle_idx] <= 1'b1;
      end
      if (clr_busy) begin
        worker_busy[cur_idx] <= 1'b0;
      end
      if (do_insert) begin
        q_count <= q_count + 1'b1;
      end else if (do_pop) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      rd_task <= worker_task[WIDX'(head.worker)];
    end
    if (mem_we) begin
      worker_task[mem_addr] <= mem_wdata;
    end
    if (state == tdpq_pkg::BK_EXEC) begin
      result <= res_next;
    end
  end

  // Sorted insert behind every entry of equal or higher priority, or a shift
  // towards the head when the head is handed out.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_insert && (CW'(i) <= q_count) && !ahead[i]) begin
        if ((i == 0) || ahead[(i > 0) ? i - 1 : 0]) begin
          q_prio[i] <= cur.priority_req;
          q_task[i] <= cur.task_id;
        end else begin
          q_prio[i] <= q_prio[(i > 0) ? i - 1 : 0];
          q_task[i] <= q_task[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop && (i + 1 < QUEUE_DEPTH)) begin
        q_prio[i] <= q_prio[(i + 1 < QUEUE_DEPTH) ? i + 1 : i];
        q_task[i] <= q_task[(i + 1 < QUEUE_DEPTH) ? i + 1 : i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/task_dispatch_priority_queue.sv]
// ----------------------------------------------------------------------------
// task_dispatch_priority_queue: worker pool dispatcher with a priority queue
// An accepted item waits in the command queue, is fetched and then executed
// by the execution unit, and its result is registered with the strobe.
// The execution unit fetches and executes each command around its worker task
// memory read and takes no new command until the last one is executed.
// Reset: all workers idle, wait queue empty, one active worker; results must
// be taken when strobed and busy flags a full command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module task_dispatch_priority_queue #(
  parameter int MAX_WORKERS = tdpq_pkg::MAX_WORKERS_DEF,
  parameter int QUEUE_DEPTH = tdpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tdpq_pkg::WCFG_W-1:0] cfg_data,
  input  wire logic                        start,
  input  wire tdpq_pkg::item_t             item,
  output logic                             busy,
  output logic                             result_valid,
  output tdpq_pkg::result_t                result
);

  logic [tdpq_pkg::WCFG_W-1:0] workers_in_use;
  logic                        push;
  logic                        pop;
  logic                        q_empty;
  logic                        q_full;
  tdpq_pkg::cmd_t              push_cmd;
  tdpq_pkg::cmd_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      workers_in_use <= tdpq_pkg::WCFG_W'(1);
    end else if (cfg_we) begin
      workers_in_use <= cfg_data;
    end
  end

  tdpq_front #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_front (
    .start  (start),
    .item   (item),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .cmd    (push_cmd)
  );

  tdpq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tdpq_back #(
    .MAX_WORKERS(MAX_WORKERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .workers_in_use (workers_in_use),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .result_valid   (result_valid),
    .result         (result)
  );

endmodule

`default_nettype wire

[sim/tdpq_checker.sv]
// ----------------------------------------------------------------------------
// tdpq_checker: result checker for the task dispatch priority queue
// Watches the command, configuration and result channels. It keeps its own
// copy of the worker pool and of the sorted wait queue, predicts the outcome
// of every accepted transaction and compares each strobed result, field by
// field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpq_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tdpq_pkg::WCFG_W-1:0] cfg_data,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire tdpq_pkg::item_t             item,
  input  wire logic                        result_valid,
  input  wire tdpq_pkg::result_t           result,
  output int                               fail_count,
  output int                               pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]                  pool_busy;
  logic [tdpq_pkg::TASK_W-1:0] pool_task [8];
  logic [31:0]                 wait_list [8];
  int unsigned                 wait_fill;
  logic [tdpq_pkg::WCFG_W-1:0] workers_cfg;
  tdpq_pkg::result_t           outcome_q [$];

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    tdpq_pkg::result_t outcome;
    int unsigned       active;
    int unsigned       capacity;
    int unsigned       pos;
    int unsigned       i;
    logic              placed;
    logic [2:0]        w;
    if (rst) begin
      pool_busy   = '0;
      wait_fill   = 0;
      workers_cfg = 4'd1;
      fail_count  = 0;
      for (i = 0; i < 8; i++) begin
        pool_task[i] = '0;
        wait_list[i] = '0;
      end
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          fail_count++;
        end else begin
          outcome = outcome_q.pop_front();
          check_field("status", 16'(outcome.status), 16'(result.status));
          check_field("dispatch_worker", 16'(outcome.dispatch_worker),
                      16'(result.dispatch_worker));
          check_field("dispatch_task", outcome.dispatch_task, result.dispatch_task);
          check_field("finished_valid", 16'(outcome.finished_valid),
                      16'(result.finished_valid));
          check_field("finished_task", outcome.finished_task, result.finished_task);
        end
      end

      if (cfg_we)
        workers_cfg = cfg_data;

      if (start && !busy) begin
        // A count of zero behaves as one worker, anything above eight as eight.
        active   = (workers_cfg == 0) ? 1 : ((workers_cfg > 8) ? 8 : workers_cfg);
        capacity = (active < 4) ? 4 : active;
        outcome        = '0;
        outcome.status = tdpq_pkg::ST_IDLE;
        if (!item.mode) begin
          placed = 1'b0;
          for (i = 0; i < active; i++) begin
            if (!pool_busy[i]) begin
              pool_busy[i]            = 1'b1;
              pool_task[i]            = item.task_id;
              outcome.status          = tdpq_pkg::ST_DISPATCHED;
              outcome.dispatch_worker = i[2:0];
              outcome.dispatch_task   = item.task_id;
              placed                  = 1'b1;
              break;
            end
          end
          if (!placed) begin
            if (wait_fill < capacity) begin
              // Ascending order; a newcomer goes ahead of equal priorities, so
              // popping from the top end serves the oldest of a tie first.
              pos = wait_fill;
              for (i = 0; i < wait_fill; i++) begin
                if (wait_list[i][31:16] >= item.priority_req) begin
                  pos = i;
                  break;
                end
              end
              for (i = wait_fill; i > pos; i--)
                wait_list[i] = wait_list[i-1];
              wait_list[pos] = {item.priority_req, item.task_id};
              wait_fill++;
              outcome.status = tdpq_pkg::ST_QUEUED;
            end else begin
              outcome.status = tdpq_pkg::ST_FULL;
            end
          end
        end else begin
          w = item.worker;
          if (pool_busy[w]) begin
            outcome.finished_valid = 1'b1;
            outcome.finished_task  = pool_task[w];
            if (w < active && wait_fill > 0) begin
              wait_fill--;
              pool_task[w]            = wait_list[wait_fill][15:0];
              outcome.dispatch_task   = wait_list[wait_fill][15:0];
              outcome.dispatch_worker = w;
              outcome.status          = tdpq_pkg::ST_DISPATCHED;
            end else begin
              pool_busy[w]   = 1'b0;
              outcome.status = tdpq_pkg::ST_IDLE;
            end
          end
        end
        outcome_q.push_back(outcome);
      end
      pending <= outcome_q.size();
    end
  end

endmodule

`default_nettype wire

[sim/task_dispatch_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// task_dispatch_priority_queue_tb: top level testbench of the dispatcher
// Drives a directed run through dispatch, queueing, rejection, stray and
// out-of-range completions and worker count changes, then several phases of
// random submits and completions under varying worker counts, with random
// idle bursts on the command side. Checking is done by tdpq_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module task_dispatch_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        cfg_we   = 1'b0;
  logic [tdpq_pkg::WCFG_W-1:0] cfg_data = '0;
  logic                        start    = 1'b0;
  tdpq_pkg::item_t             item     = '0;
  logic                        busy;
  logic                        result_valid;
  tdpq_pkg::result_t           result;
  int                          fail_count;
  int                          pending;
  int                          stall_cycles = 0;
  int unsigned                 active_now   = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task_dispatch_priority_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  tdpq_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Start is left high after acceptance so that back-to-back transactions
  // are possible; only idle bursts and drains lower it.
  task automatic issue_command(input tdpq_pkg::item_t cmd);
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic submit(input logic [15:0] task_id, input logic [15:0] prio);
    tdpq_pkg::item_t cmd;
    cmd              = '0;
    cmd.task_id      = task_id;
    cmd.priority_req = prio;
    issue_command(cmd);
  endtask

  task automatic complete(input logic [2:0] w);
    tdpq_pkg::item_t cmd;
    cmd        = '0;
    cmd.mode   = 1'b1;
    cmd.worker = w;
    issue_command(cmd);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // The worker count is only changed once every outstanding result is back.
  task automatic set_workers(input logic [tdpq_pkg::WCFG_W-1:0] count);
    drain();
    cfg_we     <= 1'b1;
    cfg_data   <= count;
    active_now  = (count == 0) ? 1 : ((count > 8) ? 8 : count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("task_dispatch_priority_queue_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    tdpq_pkg::item_t cmd;
    int unsigned     submit_pct;
    int unsigned     pick;
    logic            quiet;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One worker: fill the wait queue with ties and extremes, overflow it,
    // then drain it through the single worker.
    submit(16'h0000, 16'h0000);
    submit(16'hFFFF, 16'hFFFF);
    submit(16'h1234, 16'h0005);
    submit(16'h1111, 16'h0005);
    submit(16'h2222, 16'h0000);
    submit(16'h3333, 16'h8000);
    complete(3'd7);
    repeat (5) complete(3'd0);
    complete(3'd0);

    // A count above the maximum acts as eight workers.
    set_workers(4'd15);
    submit(16'hA000, 16'h0001);
    submit(16'hA001, 16'h0002);
    submit(16'hA002, 16'h0003);
    // Lowering the count strands busy workers beyond it; they finish and idle.
    set_workers(4'd1);
    complete(3'd2);
    submit(16'hB000, 16'h7FFF);
    set_workers(4'd0);
    complete(3'd1);
    complete(3'd0);
    submit(16'hB001, 16'h0010);
    // Raising the count again sends a new submit to a newly active worker.
    set_workers(4'd8);
    submit(16'hC000, 16'h0020);
    complete(3'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_workers(4'd8);
        1:       set_workers(4'd1);
        2:       set_workers(4'd15);
        3:       set_workers(4'd0);
        4:       set_workers(4'd4);
        5:       set_workers(4'd2);
        default: set_workers(4'($urandom_range(0, 15)));
      endcase
      submit_pct = $urandom_range(30, 75);
      quiet      = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd.mode    = ($urandom_range(0, 99) >= submit_pct);
        cmd.task_id = 16'($urandom);
        pick        = $urandom_range(0, 3);
        if (pick == 0)
          cmd.priority_req = 16'($urandom_range(0, 3));
        else if (pick == 1)
          cmd.priority_req = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
          cmd.priority_req = 16'($urandom);
        // Completions mostly name an active worker, which is usually busy.
        if ($urandom_range(0, 4) != 0)
          cmd.worker = 3'($urandom_range(0, active_now - 1));
        else
          cmd.worker = 3'($urandom_range(0, 7));
        issue_command(cmd);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("task_dispatch_priority_queue_tb passed");
    end else begin
      $display("task_dispatch_priority_queue_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/tdpq_pkg.sv
rtl/tdpq_front.sv
rtl/tdpq_cmd_fifo.sv
rtl/tdpq_back.sv
rtl/task_dispatch_priority_queue.sv
sim/tdpq_checker.sv
sim/task_dispatch_priority_queue_tb.sv
